/* hw/rtl/rfft_pkg.sv */
// Shared constants, types, twiddle table and helpers for the radix-2 frame FFT.
package rfft_pkg;

  localparam int LOG2_POINTS    = 10;
  localparam int POINTS         = 1 << LOG2_POINTS;
  localparam int HALF_POINTS    = POINTS >> 1;
  localparam int QUARTER_POINTS = POINTS >> 2;
  localparam int ADDR_W         = LOG2_POINTS;
  localparam int BF_W           = LOG2_POINTS - 1;
  localparam int STAGE_W        = $clog2(LOG2_POINTS);
  localparam int SAMPLE_W       = 16;
  localparam int BIN_W          = 10;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [2*SAMPLE_W-1:0] cplx_t;

  typedef struct packed {
    addr_t pos;
    logic  produce;
    logic  frame_end;
  } token_t;

  typedef struct packed {
    addr_t ld_addr;
    logic  xfer_done;
  } back_ctl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_BIN,
    B_COPY,
    B_RD,
    B_MUL,
    B_SUM,
    B_WA,
    B_WB
  } back_state_t;

  typedef cplx_t tw_rom_t [HALF_POINTS];

  function automatic addr_t bit_reverse(addr_t v);
    addr_t r;
    for (int b = 0; b < ADDR_W; b++) begin
      r[b] = v[ADDR_W-1-b];
    end
    return r;
  endfunction

  // restoring long division, used only while building the table
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic longint taylor(longint unsigned x, bit odd);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned d;
    longint sum;
    x2 = (x * x) >> 30;
    term = odd ? x : (64'd1 << 30);
    sum = longint'(term);
    for (int n = 1; n <= 10; n++) begin
      d = odd ? 64'(2 * n * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = udiv((term * x2) >> 30, d);
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  function automatic logic [SAMPLE_W-1:0] to_q15(longint v);
    longint unsigned r;
    longint vc;
    vc = (v < 0) ? 64'sd0 : v;
    r = (64'(vc) + (64'd1 << 14)) >> 15;
    return (r > 64'd32767) ? 16'h7fff : r[SAMPLE_W-1:0];
  endfunction

  function automatic tw_rom_t build_twiddles();
    tw_rom_t rom;
    longint unsigned q;
    longint unsigned a;
    logic [SAMPLE_W-1:0] c;
    logic [SAMPLE_W-1:0] sn;
    for (int k = 0; k < HALF_POINTS; k++) begin
      q = (k < QUARTER_POINTS) ? 64'(k) : 64'(k - QUARTER_POINTS);
      a = (q * PI_Q30) >> (LOG2_POINTS - 1);
      c = to_q15(taylor(a, 1'b0));
      sn = to_q15(taylor(a, 1'b1));
      if (k < QUARTER_POINTS) begin
        rom[k] = {c, 16'(-sn)};
      end else begin
        rom[k] = {16'(-sn), 16'(-c)};
      end
    end
    return rom;
  endfunction

  localparam tw_rom_t TWIDDLE = build_twiddles();

endpackage

/* hw/rtl/rfft_front.sv */
// Input side: accepts sample beats, fills the load buffer and tags each beat for the back end.
module rfft_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [rfft_pkg::SAMPLE_W-1:0] in_sample_re,
  input  logic signed [rfft_pkg::SAMPLE_W-1:0] in_sample_im,
  output logic                            q_push,
  output rfft_pkg::token_t                q_token,
  input  logic                            q_full,
  input  rfft_pkg::back_ctl_t             ctl,
  output rfft_pkg::cplx_t                 ld_rdata
);

  logic                      inverse_r;
  rfft_pkg::addr_t           pos_r, pos_nxt;
  logic                      ready_r, ready_nxt;
  logic                      wait_r, wait_nxt;
  logic                      accept;
  logic                      frame_end;
  logic signed [rfft_pkg::SAMPLE_W-1:0] im_c;
  rfft_pkg::cplx_t           ld_mem [rfft_pkg::POINTS];
  rfft_pkg::cplx_t           ld_rdata_r;

  assign in_stall  = wait_r | q_full;
  assign accept    = in_valid & ~in_stall;
  assign frame_end = (pos_r == rfft_pkg::ADDR_W'(rfft_pkg::POINTS - 1));

  always_comb begin
    if (!inverse_r) begin
      im_c = in_sample_im;
    end else if (in_sample_im == rfft_pkg::SAMPLE_MIN) begin
      im_c = rfft_pkg::SAMPLE_MAX;
    end else begin
      im_c = -in_sample_im;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    ready_nxt = ready_r;
    wait_nxt  = wait_r;
    if (ctl.xfer_done) begin
      wait_nxt = 1'b0;
    end
    if (accept) begin
      pos_nxt = pos_r + 1'b1;
      if (frame_end) begin
        ready_nxt = 1'b1;
        wait_nxt  = 1'b1;
      end
    end
  end

  assign q_push            = accept;
  assign q_token.pos       = pos_r;
  assign q_token.produce   = ready_r;
  assign q_token.frame_end = frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inverse_r <= 1'b0;
      pos_r     <= '0;
      ready_r   <= 1'b0;
      wait_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        inverse_r <= cfg_wdata;
      end
      pos_r   <= pos_nxt;
      ready_r <= ready_nxt;
      wait_r  <= wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_mem[pos_r] <= {in_sample_re, im_c};
    end
    ld_rdata_r <= ld_mem[ctl.ld_addr];
  end

  assign ld_rdata = ld_rdata_r;

endmodule

/* hw/rtl/rfft_queue.sv */
// Short token queue between the front and back ends.
module rfft_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rfft_pkg::token_t push_token,
  output logic             full,
  input  logic             pop,
  output rfft_pkg::token_t pop_token,
  output logic             pop_valid
);

  rfft_pkg::token_t              entry_r [rfft_pkg::QDEPTH];
  logic [rfft_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [rfft_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [rfft_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign full      = (cnt_r == rfft_pkg::QCNT_W'(rfft_pkg::QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_token = entry_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

/* hw/rtl/rfft_back.sv */
// Back end: spectrum buffer, bin output register and the shared butterfly engine.
module rfft_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  rfft_pkg::token_t                      q_token,
  output logic                                  q_pop,
  output rfft_pkg::back_ctl_t                   ctl,
  input  rfft_pkg::cplx_t                       ld_rdata,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rfft_pkg::SAMPLE_W-1:0]  out_bin_re,
  output logic signed [rfft_pkg::SAMPLE_W-1:0]  out_bin_im,
  output logic [rfft_pkg::BIN_W-1:0]            out_bin_index,
  output logic                                  out_last_bin
);

  rfft_pkg::back_state_t          state_r, state_nxt;
  rfft_pkg::token_t               tok_r, tok_nxt;
  rfft_pkg::addr_t                cnt_r, cnt_nxt;
  logic [rfft_pkg::STAGE_W-1:0]   stage_r, stage_nxt;
  logic [rfft_pkg::BF_W-1:0]      bf_r, bf_nxt;
  logic                           cp_v_r, cp_v_nxt;
  rfft_pkg::addr_t                cp_idx_r;

  rfft_pkg::cplx_t                sp_mem [rfft_pkg::POINTS];
  rfft_pkg::cplx_t                rd_a_r, rd_b_r, tw_r;
  rfft_pkg::addr_t                rd_a_addr;
  logic                           sp_we;
  rfft_pkg::addr_t                sp_waddr;
  rfft_pkg::cplx_t                sp_wdata;

  rfft_pkg::addr_t                bf_ext;
  rfft_pkg::addr_t                half_mask;
  rfft_pkg::addr_t                j_addr;
  rfft_pkg::addr_t                g_addr;
  rfft_pkg::addr_t                b_addr;
  logic [rfft_pkg::BF_W-1:0]      tw_addr;

  logic signed [31:0]             p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [rfft_pkg::SAMPLE_W-1:0] a_re_r, a_im_r;
  logic signed [32:0]             tr_r, ti_r;
  rfft_pkg::cplx_t                a_new, b_new;
  rfft_pkg::cplx_t                b_new_r;

  logic                           out_valid_r;
  logic                           out_load;
  logic                           done;

  function automatic logic [rfft_pkg::SAMPLE_W-1:0] bfly_half(
    logic signed [rfft_pkg::SAMPLE_W-1:0] a, logic signed [32:0] t, logic sub);
    logic signed [33:0] ar;
    logic signed [33:0] s;
    logic signed [17:0] h;
    ar = {{3{a[15]}}, a, 15'd0};
    s  = sub ? (ar - 34'(t)) : (ar + 34'(t));
    h  = s[33:16];
    if (h > 18'sd32767) begin
      return 16'h7fff;
    end else if (h < -18'sd32768) begin
      return 16'h8000;
    end else begin
      return h[15:0];
    end
  endfunction

  // butterfly addressing for the current stage
  assign bf_ext    = {1'b0, bf_r};
  assign half_mask = (rfft_pkg::ADDR_W'(1) << stage_r) - 1'b1;
  assign j_addr    = bf_ext & half_mask;
  assign g_addr    = ((bf_ext >> stage_r) << (stage_r + 1'b1)) | j_addr;
  assign b_addr    = g_addr | (rfft_pkg::ADDR_W'(1) << stage_r);
  assign tw_addr   = rfft_pkg::BF_W'(j_addr << (rfft_pkg::LOG2_POINTS - 1 - stage_r));

  assign a_new = {bfly_half(a_re_r, tr_r, 1'b0), bfly_half(a_im_r, ti_r, 1'b0)};
  assign b_new = {bfly_half(a_re_r, tr_r, 1'b1), bfly_half(a_im_r, ti_r, 1'b1)};

  assign ctl.ld_addr   = rfft_pkg::bit_reverse(cnt_r);
  assign ctl.xfer_done = done;

  always_comb begin
    state_nxt = state_r;
    tok_nxt   = tok_r;
    cnt_nxt   = cnt_r;
    stage_nxt = stage_r;
    bf_nxt    = bf_r;
    cp_v_nxt  = 1'b0;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    done      = 1'b0;
    rd_a_addr = g_addr;
    sp_we     = cp_v_r;
    sp_waddr  = cp_idx_r;
    sp_wdata  = ld_rdata;
    unique case (state_r)
      rfft_pkg::B_IDLE: begin
        rd_a_addr = q_token.pos;
        if (q_valid && (!q_token.produce || !out_valid_r)) begin
          q_pop   = 1'b1;
          tok_nxt = q_token;
          if (q_token.produce) begin
            state_nxt = rfft_pkg::B_BIN;
          end else if (q_token.frame_end) begin
            state_nxt = rfft_pkg::B_COPY;
            cnt_nxt   = '0;
          end
        end
      end
      rfft_pkg::B_BIN: begin
        out_load = 1'b1;
        if (tok_r.frame_end) begin
          state_nxt = rfft_pkg::B_COPY;
          cnt_nxt   = '0;
        end else begin
          state_nxt = rfft_pkg::B_IDLE;
        end
      end
      rfft_pkg::B_COPY: begin
        cp_v_nxt = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == rfft_pkg::ADDR_W'(rfft_pkg::POINTS - 1)) begin
          state_nxt = rfft_pkg::B_RD;
          stage_nxt = '0;
          bf_nxt    = '0;
        end
      end
      rfft_pkg::B_RD: begin
        state_nxt = rfft_pkg::B_MUL;
      end
      rfft_pkg::B_MUL: begin
        state_nxt = rfft_pkg::B_SUM;
      end
      rfft_pkg::B_SUM: begin
        state_nxt = rfft_pkg::B_WA;
      end
      rfft_pkg::B_WA: begin
        sp_we     = 1'b1;
        sp_waddr  = g_addr;
        sp_wdata  = a_new;
        state_nxt = rfft_pkg::B_WB;
      end
      rfft_pkg::B_WB: begin
        sp_we    = 1'b1;
        sp_waddr = b_addr;
        sp_wdata = b_new_r;
        bf_nxt   = bf_r + 1'b1;
        if (bf_r == rfft_pkg::BF_W'(rfft_pkg::HALF_POINTS - 1)) begin
          if (stage_r == rfft_pkg::STAGE_W'(rfft_pkg::LOG2_POINTS - 1)) begin
            done      = 1'b1;
            state_nxt = rfft_pkg::B_IDLE;
          end else begin
            stage_nxt = stage_r + 1'b1;
            state_nxt = rfft_pkg::B_RD;
          end
        end else begin
          state_nxt = rfft_pkg::B_RD;
        end
      end
      default: begin
        state_nxt = rfft_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfft_pkg::B_IDLE;
      cp_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cp_v_r  <= cp_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r    <= tok_nxt;
    cnt_r    <= cnt_nxt;
    stage_r  <= stage_nxt;
    bf_r     <= bf_nxt;
    cp_idx_r <= cnt_r;
    if (sp_we) begin
      sp_mem[sp_waddr] <= sp_wdata;
    end
    rd_a_r <= sp_mem[rd_a_addr];
    rd_b_r <= sp_mem[b_addr];
    tw_r   <= rfft_pkg::TWIDDLE[tw_addr];
    if (state_r == rfft_pkg::B_MUL) begin
      p_rr_r <= $signed(rd_b_r[31:16]) * $signed(tw_r[31:16]);
      p_ii_r <= $signed(rd_b_r[15:0])  * $signed(tw_r[15:0]);
      p_ri_r <= $signed(rd_b_r[31:16]) * $signed(tw_r[15:0]);
      p_ir_r <= $signed(rd_b_r[15:0])  * $signed(tw_r[31:16]);
      a_re_r <= rd_a_r[31:16];
      a_im_r <= rd_a_r[15:0];
    end
    if (state_r == rfft_pkg::B_SUM) begin
      tr_r <= 33'(p_rr_r) - 33'(p_ii_r);
      ti_r <= 33'(p_ri_r) + 33'(p_ir_r);
    end
    if (state_r == rfft_pkg::B_WA) begin
      b_new_r <= b_new;
    end
    if (out_load) begin
      out_bin_re    <= rd_a_r[31:16];
      out_bin_im    <= rd_a_r[15:0];
      out_bin_index <= rfft_pkg::BIN_W'(tok_r.pos);
      out_last_bin  <= tok_r.frame_end;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_bin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfft_pkg::B_BIN) |-> !out_valid_r)
    else $error("bin load while output register busy");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (state_r == rfft_pkg::B_IDLE))
    else $error("transform end did not return to idle");

  a_copy_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    cp_v_r |-> (state_r == rfft_pkg::B_COPY || state_r == rfft_pkg::B_RD))
    else $error("reorder write outside copy pass");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == rfft_pkg::B_IDLE && q_valid))
    else $error("token pop outside idle");
`endif

endmodule

/* hw/rtl/radix2_fft_frame_unit.sv */
// Top level of the frame-based radix-2 decimation-in-time FFT.
// Samples (Q1.15 complex) are loaded into a 2^LOG2_POINTS frame buffer; each
// sample beat after the first frame returns one bin of the previous spectrum
// (scaled by 1/N) in natural order, with last_bin on bin N-1. A non-final beat
// passes the front end and then the back end through a two-entry token queue.
// The final beat of a frame starts the transform and the input stalls until it
// ends: first the bit-reversed copy, then the butterflies on the one shared
// butterfly unit, each an unpipelined read, multiply, sum and two-write
// sequence. The first frame returns no bins. inverse_mode conjugates
// inputs only.
module radix2_fft_frame_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rfft_pkg::SAMPLE_W-1:0]  in_sample_re,
  input  logic signed [rfft_pkg::SAMPLE_W-1:0]  in_sample_im,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rfft_pkg::SAMPLE_W-1:0]  out_bin_re,
  output logic signed [rfft_pkg::SAMPLE_W-1:0]  out_bin_im,
  output logic [rfft_pkg::BIN_W-1:0]            out_bin_index,
  output logic                                  out_last_bin
);

  logic                q_push;
  rfft_pkg::token_t    q_push_token;
  logic                q_full;
  logic                q_pop;
  rfft_pkg::token_t    q_pop_token;
  logic                q_valid;
  rfft_pkg::back_ctl_t ctl;
  rfft_pkg::cplx_t     ld_rdata;

  rfft_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .q_push       (q_push),
    .q_token      (q_push_token),
    .q_full       (q_full),
    .ctl          (ctl),
    .ld_rdata     (ld_rdata)
  );

  rfft_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_token (q_push_token),
    .full       (q_full),
    .pop        (q_pop),
    .pop_token  (q_pop_token),
    .pop_valid  (q_valid)
  );

  rfft_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_token       (q_pop_token),
    .q_pop         (q_pop),
    .ctl           (ctl),
    .ld_rdata      (ld_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bin_re    (out_bin_re),
    .out_bin_im    (out_bin_im),
    .out_bin_index (out_bin_index),
    .out_last_bin  (out_last_bin)
  );

endmodule

/* tb/radix2_fft_frame_unit_checker.sv */
// Spectrum predictor and bin scoreboard for the radix-2 frame FFT unit.
module radix2_fft_frame_unit_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [rfft_pkg::SAMPLE_W-1:0]  in_sample_re,
  input  logic signed [rfft_pkg::SAMPLE_W-1:0]  in_sample_im,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [rfft_pkg::SAMPLE_W-1:0]  out_bin_re,
  input  logic signed [rfft_pkg::SAMPLE_W-1:0]  out_bin_im,
  input  logic [rfft_pkg::BIN_W-1:0]            out_bin_index,
  input  logic                                  out_last_bin,
  output int                                    errors,
  output int                                    pending,
  output int                                    bins_checked
);

  typedef struct packed {
    logic signed [rfft_pkg::SAMPLE_W-1:0] re;
    logic signed [rfft_pkg::SAMPLE_W-1:0] im;
    logic [rfft_pkg::BIN_W-1:0]           index;
    logic                                 last;
  } bin_t;

  bin_t bin_queue[$];
  int frame_re[rfft_pkg::POINTS];
  int frame_im[rfft_pkg::POINTS];
  int spec_re[rfft_pkg::POINTS];
  int spec_im[rfft_pkg::POINTS];
  longint cos_tab[rfft_pkg::HALF_POINTS];
  longint sin_tab[rfft_pkg::HALF_POINTS];
  int fill_pos;
  bit have_spectrum;
  bit conj_mode;

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic longint series(longint unsigned x, bit want_sin);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned div;
    longint acc;
    x2 = (x * x) >> 30;
    term = want_sin ? x : (64'd1 << 30);
    acc = longint'(term);
    for (int n = 1; n <= 10; n++) begin
      div = want_sin ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = ((term * x2) >> 30) / div;
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    return acc;
  endfunction

  function automatic longint round_q15(longint v);
    longint unsigned r;
    if (v < 0) v = 0;
    r = (longint'(v) + (64'd1 << 14)) >> 15;
    return (r > 32767) ? 32767 : longint'(r);
  endfunction

  function automatic int reverse_bits(int v);
    int r;
    r = 0;
    for (int b = 0; b < rfft_pkg::LOG2_POINTS; b++) r = (r << 1) | ((v >> b) & 1);
    return r;
  endfunction

  task automatic run_transform();
    int half;
    int tk;
    int b;
    longint wr;
    longint wi;
    longint tr;
    longint ti;
    longint ar;
    longint ai;
    for (int i = 0; i < rfft_pkg::POINTS; i++) begin
      spec_re[i] = frame_re[reverse_bits(i)];
      spec_im[i] = frame_im[reverse_bits(i)];
    end
    for (int s = 0; s < rfft_pkg::LOG2_POINTS; s++) begin
      half = 1 << s;
      for (int j = 0; j < half; j++) begin
        tk = (j << (rfft_pkg::LOG2_POINTS - 1 - s)) & (rfft_pkg::HALF_POINTS - 1);
        wr = cos_tab[tk];
        wi = sin_tab[tk];
        for (int g = j; g < rfft_pkg::POINTS; g += 2 * half) begin
          b = g + half;
          tr = longint'(spec_re[b]) * wr - longint'(spec_im[b]) * wi;
          ti = longint'(spec_re[b]) * wi + longint'(spec_im[b]) * wr;
          ar = longint'(spec_re[g]) * 32768;
          ai = longint'(spec_im[g]) * 32768;
          spec_re[g] = clamp16((ar + tr) >>> 16);
          spec_im[g] = clamp16((ai + ti) >>> 16);
          spec_re[b] = clamp16((ar - tr) >>> 16);
          spec_im[b] = clamp16((ai - ti) >>> 16);
        end
      end
    end
  endtask

  initial begin
    longint unsigned q;
    longint unsigned ang;
    longint c;
    longint sn;
    errors = 0;
    bins_checked = 0;
    fill_pos = 0;
    have_spectrum = 0;
    conj_mode = 0;
    for (int k = 0; k < rfft_pkg::HALF_POINTS; k++) begin
      q = (k < rfft_pkg::QUARTER_POINTS) ? k : k - rfft_pkg::QUARTER_POINTS;
      ang = (q * rfft_pkg::PI_Q30) >> (rfft_pkg::LOG2_POINTS - 1);
      c = round_q15(series(ang, 1'b0));
      sn = round_q15(series(ang, 1'b1));
      if (k < rfft_pkg::QUARTER_POINTS) begin
        cos_tab[k] = c;
        sin_tab[k] = -sn;
      end else begin
        cos_tab[k] = -sn;
        sin_tab[k] = -c;
      end
    end
  end

  assign pending = bin_queue.size();

  always @(posedge clk) begin
    bin_t want;
    int im;
    if (rst_n) begin
      if (cfg_we) conj_mode = cfg_wdata;
      if (in_valid && !in_stall) begin
        im = in_sample_im;
        if (conj_mode) im = clamp16(-longint'(im));
        if (have_spectrum) begin
          want.re = spec_re[fill_pos];
          want.im = spec_im[fill_pos];
          want.index = fill_pos[rfft_pkg::BIN_W-1:0];
          want.last = (fill_pos == rfft_pkg::POINTS - 1);
          bin_queue.push_back(want);
        end
        frame_re[fill_pos] = in_sample_re;
        frame_im[fill_pos] = im;
        if (fill_pos == rfft_pkg::POINTS - 1) begin
          run_transform();
          have_spectrum = 1;
          fill_pos = 0;
        end else begin
          fill_pos++;
        end
      end
      if (out_valid && !out_stall) begin
        if (bin_queue.size() == 0) begin
          $display("%0t: unexpected bin beat re=%0d im=%0d index=%0d last=%0b", $time,
                   out_bin_re, out_bin_im, out_bin_index, out_last_bin);
          errors++;
        end else begin
          want = bin_queue.pop_front();
          bins_checked++;
          if (want.re !== out_bin_re || want.im !== out_bin_im ||
              want.index !== out_bin_index || want.last !== out_last_bin) begin
            $display("%0t: bin mismatch expected re=%0d im=%0d index=%0d last=%0b",
                     $time, want.re, want.im, want.index, want.last);
            $display("%0t:              actual   re=%0d im=%0d index=%0d last=%0b",
                     $time, out_bin_re, out_bin_im, out_bin_index, out_last_bin);
            errors++;
          end
        end
      end
    end
  end

endmodule

/* tb/radix2_fft_frame_unit_tb.sv */
// Stimulus, idling control and verdict for the radix-2 frame FFT unit.
module radix2_fft_frame_unit_tb;

  localparam int SETTLE_CYCLES = 30000;
  localparam int STALL_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 3000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic signed [rfft_pkg::SAMPLE_W-1:0] in_sample_re;
  logic signed [rfft_pkg::SAMPLE_W-1:0] in_sample_im;
  logic out_valid;
  logic out_stall;
  logic signed [rfft_pkg::SAMPLE_W-1:0] out_bin_re;
  logic signed [rfft_pkg::SAMPLE_W-1:0] out_bin_im;
  logic [rfft_pkg::BIN_W-1:0] out_bin_index;
  logic out_last_bin;

  int errors;
  int pending;
  int bins_checked;
  int gap_pct;
  int stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int quiet_cycles;
  int samples_sent;

  radix2_fft_frame_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_bin_re   (out_bin_re),
    .out_bin_im   (out_bin_im),
    .out_bin_index(out_bin_index),
    .out_last_bin (out_last_bin)
  );

  radix2_fft_frame_unit_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_bin_re   (out_bin_re),
    .out_bin_im   (out_bin_im),
    .out_bin_index(out_bin_index),
    .out_last_bin (out_last_bin),
    .errors       (errors),
    .pending      (pending),
    .bins_checked (bins_checked)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hold off the result side on request, otherwise stall at random
  initial begin
    hold_seen = 0;
    hold_left = 0;
    out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d bins pending", quiet_cycles, pending);
      $display("radix2_fft_frame_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(logic [rfft_pkg::SAMPLE_W-1:0] re,
                             logic [rfft_pkg::SAMPLE_W-1:0] im);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_re <= re;
    in_sample_im <= im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic settle_and_set_mode(logic mode);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [rfft_pkg::SAMPLE_W-1:0] pick_sample();
    int kind;
    kind = $urandom_range(9);
    if (kind <= 5) return rfft_pkg::SAMPLE_W'($urandom);
    if (kind <= 7) begin
      case ($urandom_range(3))
        0: return rfft_pkg::SAMPLE_MIN;
        1: return rfft_pkg::SAMPLE_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    if (kind == 8) return rfft_pkg::SAMPLE_W'($urandom_range(511) - 256);
    return rfft_pkg::SAMPLE_MIN;
  endfunction

  initial begin
    logic [rfft_pkg::SAMPLE_W-1:0] edge_vals[6];
    int phase_gap[4];
    int phase_stall[4];
    edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555};
    phase_gap = '{0, 48, 0, 30};
    phase_stall = '{0, 0, 48, 30};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    in_valid <= 1'b0;
    in_sample_re <= '0;
    in_sample_im <= '0;
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    quiet_cycles = 0;
    samples_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    settle_and_set_mode(1'b0);
    for (int i = 0; i < 12; i++) send_sample(edge_vals[i % 6], edge_vals[(i + 3) % 6]);
    settle_and_set_mode(1'b1);
    for (int i = 0; i < 12; i++) send_sample(edge_vals[(i + 1) % 6], edge_vals[i % 2]);

    for (int p = 0; p < 4; p++) begin
      settle_and_set_mode(p % 2 == 0);
      gap_pct = phase_gap[p];
      stall_pct = phase_stall[p];
      for (int i = 0; i < 470; i++) begin
        if (p == 2 && i == 200) hold_req = hold_req + 1;
        send_sample(pick_sample(), pick_sample());
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("sent %0d samples over both transform directions, checked %0d spectrum bins",
             samples_sent, bins_checked);
    $display("idling covered sender gaps, receiver stalls and a long receiver hold-off");
    if (errors == 0 && pending == 0) begin
      $display("radix2_fft_frame_unit_tb: clean");
    end else begin
      $display("radix2_fft_frame_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rfft_pkg.sv
hw/rtl/rfft_front.sv
hw/rtl/rfft_queue.sv
hw/rtl/rfft_back.sv
hw/rtl/radix2_fft_frame_unit.sv
tb/radix2_fft_frame_unit_checker.sv
tb/radix2_fft_frame_unit_tb.sv
